/* rtl/pmu_pkg.sv */
// pmu_pkg: shared types and constants of the performance monitor unit
// used by the interfaces, the counter slot and the top level; no dependencies
package pmu_pkg;

    localparam int NUM_EVENT_COUNTERS = 4;
    localparam int DATA_W             = 32;
    localparam int SEL_W              = 8;
    localparam int IDX_W              = 4;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    localparam logic [IDX_W-1:0] REG_CONTROL = 4'd0;
    localparam logic [IDX_W-1:0] REG_CYCLES  = 4'd1;
    localparam logic [IDX_W-1:0] REG_IRQ_EN  = 4'd6;
    localparam logic [IDX_W-1:0] REG_FLAGS   = 4'd7;
    localparam logic [IDX_W-1:0] REG_EVSEL   = 4'd8;

    localparam logic LAYOUT_PACKED = 1'b0;
    localparam logic LAYOUT_SPLIT  = 1'b1;

    localparam logic [DATA_W-1:0] CTRL_WRITE_MASK = 32'h0FFF_F77F;

    localparam int CTRL_ENABLE_BIT     = 0;
    localparam int CTRL_CLR_EVENTS_BIT = 1;
    localparam int CTRL_CLR_CYCLES_BIT = 2;
    localparam int CTRL_DIVIDER_BIT    = 3;
    localparam int PK_IE_EV0_BIT       = 4;
    localparam int PK_IE_EV1_BIT       = 5;
    localparam int PK_IE_CYC_BIT       = 6;
    localparam int PK_OV_EV0_BIT       = 8;
    localparam int PK_OV_EV1_BIT       = 9;
    localparam int PK_OV_CYC_BIT       = 10;
    localparam int PK_SEL0_LSB         = 12;
    localparam int PK_SEL1_LSB         = 20;

    // slots within the flag and enable vectors
    localparam int SLOT_CYC = 0;
    localparam int SLOT_EV0 = 1;
    localparam int SLOT_EV1 = 2;

    typedef struct packed {
        logic clear;
        logic load;
        logic incr;
    } cnt_ctrl_t;

endpackage

/* rtl/pmu_ifs.sv */
// pmu_ifs: valid/ready channel interfaces of the performance monitor unit
// depends on pmu_pkg for field widths
interface pmu_item_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      command;
    logic [pmu_pkg::IDX_W-1:0]       reg_index;
    logic [pmu_pkg::DATA_W-1:0]      write_data;
    logic [pmu_pkg::DATA_W-1:0]      event_lines;

    modport source (output valid, command, reg_index, write_data, event_lines, input ready);
    modport sink   (input valid, command, reg_index, write_data, event_lines, output ready);
endinterface

interface pmu_result_if;
    logic                            valid;
    logic                            ready;
    logic [pmu_pkg::DATA_W-1:0]      read_data;
    logic                            irq;

    modport source (output valid, read_data, irq, input ready);
    modport sink   (input valid, read_data, irq, output ready);
endinterface

interface pmu_cfg_if;
    logic valid;
    logic ready;
    logic layout;

    modport source (output valid, layout, input ready);
    modport sink   (input valid, layout, output ready);
endinterface

/* rtl/pmu_counter.sv */
// pmu_slot_counter: one 32-bit counter slot with clear, load and increment
// depends on pmu_pkg for the control struct and data width
module pmu_slot_counter
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pmu_pkg::cnt_ctrl_t          ctrl,
    input  logic [pmu_pkg::DATA_W-1:0]  load_value,
    output logic [pmu_pkg::DATA_W-1:0]  value,
    output logic                        wrap
);

    logic [pmu_pkg::DATA_W-1:0] cnt_reg;
    logic [pmu_pkg::DATA_W-1:0] cnt_next;

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            cnt_next = '0;
        end
        else if (ctrl.load)
        begin
            cnt_next = load_value;
        end
        else if (ctrl.incr)
        begin
            cnt_next = cnt_reg + pmu_pkg::DATA_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    assign wrap  = ctrl.incr && !ctrl.clear && !ctrl.load && (&cnt_reg);
    assign value = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/performance_monitor_unit_core.sv */
// performance_monitor_unit_core: cycle and event counters behind a register port
// depends on pmu_pkg, pmu_ifs and pmu_slot_counter
//
// channels: item carries one transaction per tick, register read or register
// write; result returns one transaction per item with read_data and irq, where
// irq reflects the state after that item. cfg writes the layout register
// (0 packed three-counter layout, 1 five-counter layout); it is always ready
// and the user must write it only while no item is in flight; the block does
// not enforce this. An accepted item passes the input register, then the result
// register, before it appears on result.
// throughput: one item per cycle as long as result is taken; all counters update
// in parallel in the single stage between the input register and the result register.
// reset: counters, enables, flags and event selects clear, counting is
// disabled and the layout returns to the five-counter layout.
// stall: when result is not taken, the result register holds, the input
// register keeps one more item and item.ready then drops until result moves.
module performance_monitor_unit_core
#(
    parameter int NUM_EVENT_COUNTERS = pmu_pkg::NUM_EVENT_COUNTERS
)
(
    input  logic          clk,
    input  logic          rst_n,
    pmu_item_if.sink      item,
    pmu_result_if.source  result,
    pmu_cfg_if.sink       cfg
);

    localparam int NUM_SLOTS = NUM_EVENT_COUNTERS + 1;
    localparam int DW        = pmu_pkg::DATA_W;
    localparam int SW        = pmu_pkg::SEL_W;

    logic                           layout_reg;

    logic                           s_valid_reg;
    logic                           s_valid_next;
    pmu_pkg::cmd_t                  s_cmd_reg;
    logic [pmu_pkg::IDX_W-1:0]      s_idx_reg;
    logic [DW-1:0]                  s_wdata_reg;
    logic [DW-1:0]                  s_lines_reg;

    logic                           r_valid_reg;
    logic                           r_valid_next;
    logic [DW-1:0]                  r_data_reg;
    logic [DW-1:0]                  r_data_next;
    logic                           r_irq_reg;
    logic                           r_irq_next;

    logic                           en_reg;
    logic                           en_next;
    logic                           div_reg;
    logic                           div_next;
    logic [NUM_SLOTS-1:0]           ie_reg;
    logic [NUM_SLOTS-1:0]           ie_next;
    logic [NUM_SLOTS-1:0]           flags_reg;
    logic [NUM_SLOTS-1:0]           flags_next;
    logic [NUM_EVENT_COUNTERS-1:0][SW-1:0] sel_reg;
    logic [NUM_EVENT_COUNTERS-1:0][SW-1:0] sel_next;

    logic                           advance;
    logic                           is_tick;
    logic                           is_write;
    logic                           ctrl_wr;
    logic                           packed_wr;
    logic                           split_mode;
    logic [DW-1:0]                  ctrl_v;
    logic [NUM_SLOTS-1:0]           act;
    logic [NUM_SLOTS-1:0]           cnt_hit;
    logic [NUM_SLOTS-1:0]           wraps;
    logic [NUM_EVENT_COUNTERS-1:0]  line_hit;
    logic [NUM_SLOTS-1:0][DW-1:0]   cnt_val;
    pmu_pkg::cnt_ctrl_t [NUM_SLOTS-1:0] cnt_ctrl;

    // handshake
    assign advance      = s_valid_reg && (!r_valid_reg || result.ready);
    assign item.ready   = !s_valid_reg || advance;
    assign cfg.ready    = 1'b1;
    assign result.valid = r_valid_reg;
    assign result.read_data = r_data_reg;
    assign result.irq   = r_irq_reg;

    always_comb
    begin
        s_valid_next = s_valid_reg;
        if (item.valid && item.ready)
        begin
            s_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s_valid_next = 1'b0;
        end
        r_valid_next = r_valid_reg;
        if (advance)
        begin
            r_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            r_valid_next = 1'b0;
        end
    end

    // decode
    assign split_mode = (layout_reg == pmu_pkg::LAYOUT_SPLIT);
    assign is_tick    = advance && (s_cmd_reg == pmu_pkg::CMD_TICK);
    assign is_write   = advance && (s_cmd_reg == pmu_pkg::CMD_WRITE);
    assign ctrl_wr    = is_write && (s_idx_reg == pmu_pkg::REG_CONTROL);
    assign packed_wr  = ctrl_wr && !split_mode;
    assign ctrl_v     = s_wdata_reg & pmu_pkg::CTRL_WRITE_MASK;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_EVENT_COUNTERS; gi++)
        begin : g_line
            assign line_hit[gi] = (sel_reg[gi][SW-1:5] == '0) && s_lines_reg[sel_reg[gi][4:0]];
        end

        for (gi = 0; gi < NUM_SLOTS; gi++)
        begin : g_slot
            // packed layout keeps the cycle counter and two event counters
            assign act[gi]     = split_mode || (gi <= pmu_pkg::SLOT_EV1);
            assign cnt_hit[gi] = act[gi] && (s_idx_reg == pmu_pkg::IDX_W'(gi + 1));
            assign cnt_ctrl[gi].load = is_write && cnt_hit[gi];
            if (gi == pmu_pkg::SLOT_CYC)
            begin : g_cyc
                assign cnt_ctrl[gi].clear = ctrl_wr && ctrl_v[pmu_pkg::CTRL_CLR_CYCLES_BIT];
                assign cnt_ctrl[gi].incr  = is_tick && en_reg;
            end
            else
            begin : g_evt
                assign cnt_ctrl[gi].clear = ctrl_wr && ctrl_v[pmu_pkg::CTRL_CLR_EVENTS_BIT];
                assign cnt_ctrl[gi].incr  = is_tick && en_reg && act[gi] && line_hit[gi-1];
            end

            pmu_slot_counter u_counter
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cnt_ctrl[gi]),
                .load_value (s_wdata_reg),
                .value      (cnt_val[gi]),
                .wrap       (wraps[gi])
            );
        end
    endgenerate

    // control, enable, flag and select updates
    always_comb
    begin
        en_next    = en_reg;
        div_next   = div_reg;
        ie_next    = ie_reg;
        flags_next = flags_reg | wraps;
        sel_next   = sel_reg;
        if (ctrl_wr)
        begin
            en_next  = ctrl_v[pmu_pkg::CTRL_ENABLE_BIT];
            div_next = ctrl_v[pmu_pkg::CTRL_DIVIDER_BIT];
        end
        if (packed_wr)
        begin
            ie_next[pmu_pkg::SLOT_CYC] = ctrl_v[pmu_pkg::PK_IE_CYC_BIT];
            ie_next[pmu_pkg::SLOT_EV0] = ctrl_v[pmu_pkg::PK_IE_EV0_BIT];
            ie_next[pmu_pkg::SLOT_EV1] = ctrl_v[pmu_pkg::PK_IE_EV1_BIT];
            if (ctrl_v[pmu_pkg::PK_OV_CYC_BIT])
            begin
                flags_next[pmu_pkg::SLOT_CYC] = 1'b0;
            end
            if (ctrl_v[pmu_pkg::PK_OV_EV0_BIT])
            begin
                flags_next[pmu_pkg::SLOT_EV0] = 1'b0;
            end
            if (ctrl_v[pmu_pkg::PK_OV_EV1_BIT])
            begin
                flags_next[pmu_pkg::SLOT_EV1] = 1'b0;
            end
            sel_next[0] = ctrl_v[pmu_pkg::PK_SEL0_LSB +: SW];
            sel_next[1] = ctrl_v[pmu_pkg::PK_SEL1_LSB +: SW];
        end
        if (is_write && split_mode)
        begin
            if (s_idx_reg == pmu_pkg::REG_IRQ_EN)
            begin
                ie_next = s_wdata_reg[NUM_SLOTS-1:0] & act;
            end
            if (s_idx_reg == pmu_pkg::REG_FLAGS)
            begin
                flags_next = flags_reg & ~s_wdata_reg[NUM_SLOTS-1:0];
            end
            if (s_idx_reg == pmu_pkg::REG_EVSEL)
            begin
                for (int k = 0; k < NUM_EVENT_COUNTERS; k++)
                begin
                    sel_next[k] = s_wdata_reg[SW*k +: SW];
                end
            end
        end
    end

    // read path
    always_comb
    begin
        logic [DW-1:0] rd_ctrl;
        logic [DW-1:0] rd_cnt;
        logic [DW-1:0] rd_sel;
        rd_ctrl = '0;
        rd_ctrl[pmu_pkg::CTRL_ENABLE_BIT]  = en_reg;
        rd_ctrl[pmu_pkg::CTRL_DIVIDER_BIT] = div_reg;
        if (!split_mode)
        begin
            rd_ctrl[pmu_pkg::PK_IE_EV0_BIT] = ie_reg[pmu_pkg::SLOT_EV0];
            rd_ctrl[pmu_pkg::PK_IE_EV1_BIT] = ie_reg[pmu_pkg::SLOT_EV1];
            rd_ctrl[pmu_pkg::PK_IE_CYC_BIT] = ie_reg[pmu_pkg::SLOT_CYC];
            rd_ctrl[pmu_pkg::PK_OV_EV0_BIT] = flags_reg[pmu_pkg::SLOT_EV0];
            rd_ctrl[pmu_pkg::PK_OV_EV1_BIT] = flags_reg[pmu_pkg::SLOT_EV1];
            rd_ctrl[pmu_pkg::PK_OV_CYC_BIT] = flags_reg[pmu_pkg::SLOT_CYC];
            rd_ctrl[pmu_pkg::PK_SEL0_LSB +: SW] = sel_reg[0];
            rd_ctrl[pmu_pkg::PK_SEL1_LSB +: SW] = sel_reg[1];
        end
        rd_cnt = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            rd_cnt = rd_cnt | (cnt_hit[i] ? cnt_val[i] : '0);
        end
        rd_sel = '0;
        for (int k = 0; k < NUM_EVENT_COUNTERS; k++)
        begin
            rd_sel[SW*k +: SW] = sel_reg[k];
        end

        r_data_next = '0;
        if (s_cmd_reg == pmu_pkg::CMD_READ)
        begin
            priority if (s_idx_reg == pmu_pkg::REG_CONTROL)
            begin
                r_data_next = rd_ctrl;
            end
            else if (|cnt_hit)
            begin
                r_data_next = rd_cnt;
            end
            else if (split_mode && s_idx_reg == pmu_pkg::REG_IRQ_EN)
            begin
                r_data_next = DW'(ie_reg & act);
            end
            else if (split_mode && s_idx_reg == pmu_pkg::REG_FLAGS)
            begin
                r_data_next = DW'(flags_reg & act);
            end
            else if (split_mode && s_idx_reg == pmu_pkg::REG_EVSEL)
            begin
                r_data_next = rd_sel;
            end
            else
            begin
                r_data_next = '0;
            end
        end
    end

    assign r_irq_next = |(flags_next & ie_next & act);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg  <= pmu_pkg::LAYOUT_SPLIT;
            s_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            r_irq_reg   <= 1'b0;
            en_reg      <= 1'b0;
            div_reg     <= 1'b0;
            ie_reg      <= '0;
            flags_reg   <= '0;
            sel_reg     <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                layout_reg <= cfg.layout;
            end
            s_valid_reg <= s_valid_next;
            r_valid_reg <= r_valid_next;
            if (advance)
            begin
                r_irq_reg <= r_irq_next;
            end
            en_reg    <= en_next;
            div_reg   <= div_next;
            ie_reg    <= ie_next;
            flags_reg <= flags_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s_cmd_reg   <= pmu_pkg::cmd_t'(item.command);
            s_idx_reg   <= item.reg_index;
            s_wdata_reg <= item.write_data;
            s_lines_reg <= item.event_lines;
        end
        if (advance)
        begin
            r_data_reg <= r_data_next;
        end
    end

`ifndef SYNTH
    a_ready_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> (!s_valid_reg || !r_valid_reg || result.ready))
        else $error("input accepted with no room in the pipe");

    a_clear_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_wr && ctrl_v[pmu_pkg::CTRL_CLR_CYCLES_BIT]) |=> (cnt_val[pmu_pkg::SLOT_CYC] == '0))
        else $error("cycle counter not cleared by control write");

    a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance || (s_cmd_reg != pmu_pkg::CMD_WRITE && !en_reg)) |=> $stable(cnt_val))
        else $error("counter changed without a tick or write");

    a_irq_source: assert property (@(posedge clk) disable iff (!rst_n)
        r_irq_reg |-> (|(flags_reg & ie_reg)))
        else $error("irq without an enabled overflow flag");

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(flags_reg))
        else $error("overflow flags changed without an item");
`endif

endmodule

/* test/performance_monitor_unit_core_test.sv */
// performance_monitor_unit_core_test: self-checking bench for the performance monitor unit core
// drives register and tick transactions through pmu_item_if and checks every result against
// a cycle-free model of the counters; depends on pmu_pkg, pmu_ifs and the core rtl
module performance_monitor_unit_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int RUN_LIMIT_NS = 200000;
    localparam int DW = pmu_pkg::DATA_W;
    localparam int IW = pmu_pkg::IDX_W;
    localparam int SW = pmu_pkg::SEL_W;

    typedef struct {
        pmu_pkg::cmd_t command;
        logic [IW-1:0] reg_index;
        logic [DW-1:0] write_data;
        logic [DW-1:0] event_lines;
    } access_t;

    typedef struct {
        logic [DW-1:0] read_data;
        logic          irq;
    } readback_t;

    logic clk = 1'b0;
    logic rst_n;

    pmu_item_if   item_ch();
    pmu_result_if result_ch();
    pmu_cfg_if    cfg_ch();

    performance_monitor_unit_core DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #1 clk = ~clk;

    access_t   access_q[$];
    readback_t readback_q[$];
    access_t   on_wire;
    int        errors = 0;
    int        src_idle = 33;
    int        sink_idle = 33;
    logic      sink_hold = 1'b0;

    // model state
    logic          pmu_layout;
    logic          pmu_count_on;
    logic          pmu_divider;
    logic [4:0]    pmu_irq_en;
    logic [4:0]    pmu_flags;
    logic [SW-1:0] pmu_sel[4];
    logic [DW-1:0] pmu_count[5];

    function automatic int live_events();
        int n;
        n = (pmu_pkg::NUM_EVENT_COUNTERS > 4) ? 4 : pmu_pkg::NUM_EVENT_COUNTERS;
        if (pmu_layout == pmu_pkg::LAYOUT_PACKED && n > 2)
            n = 2;
        return n;
    endfunction

    function automatic logic [4:0] live_mask();
        return 5'((1 << (live_events() + 1)) - 1);
    endfunction

    function automatic logic [DW-1:0] control_value();
        logic [DW-1:0] v;
        v = '0;
        v[pmu_pkg::CTRL_ENABLE_BIT]  = pmu_count_on;
        v[pmu_pkg::CTRL_DIVIDER_BIT] = pmu_divider;
        if (pmu_layout == pmu_pkg::LAYOUT_PACKED)
        begin
            v[pmu_pkg::PK_IE_EV0_BIT] = pmu_irq_en[pmu_pkg::SLOT_EV0];
            v[pmu_pkg::PK_IE_EV1_BIT] = pmu_irq_en[pmu_pkg::SLOT_EV1];
            v[pmu_pkg::PK_IE_CYC_BIT] = pmu_irq_en[pmu_pkg::SLOT_CYC];
            v[pmu_pkg::PK_OV_EV0_BIT] = pmu_flags[pmu_pkg::SLOT_EV0];
            v[pmu_pkg::PK_OV_EV1_BIT] = pmu_flags[pmu_pkg::SLOT_EV1];
            v[pmu_pkg::PK_OV_CYC_BIT] = pmu_flags[pmu_pkg::SLOT_CYC];
            v[pmu_pkg::PK_SEL0_LSB +: SW] = pmu_sel[0];
            v[pmu_pkg::PK_SEL1_LSB +: SW] = pmu_sel[1];
        end
        return v;
    endfunction

    function automatic void control_write(logic [DW-1:0] d);
        logic [DW-1:0] v;
        v = d & pmu_pkg::CTRL_WRITE_MASK;
        pmu_count_on = v[pmu_pkg::CTRL_ENABLE_BIT];
        pmu_divider  = v[pmu_pkg::CTRL_DIVIDER_BIT];
        if (v[pmu_pkg::CTRL_CLR_EVENTS_BIT])
            for (int k = 1; k < 5; k++)
                pmu_count[k] = '0;
        if (v[pmu_pkg::CTRL_CLR_CYCLES_BIT])
            pmu_count[pmu_pkg::SLOT_CYC] = '0;
        if (pmu_layout == pmu_pkg::LAYOUT_PACKED)
        begin
            pmu_irq_en[pmu_pkg::SLOT_EV0] = v[pmu_pkg::PK_IE_EV0_BIT];
            pmu_irq_en[pmu_pkg::SLOT_EV1] = v[pmu_pkg::PK_IE_EV1_BIT];
            pmu_irq_en[pmu_pkg::SLOT_CYC] = v[pmu_pkg::PK_IE_CYC_BIT];
            if (v[pmu_pkg::PK_OV_EV0_BIT])
                pmu_flags[pmu_pkg::SLOT_EV0] = 1'b0;
            if (v[pmu_pkg::PK_OV_EV1_BIT])
                pmu_flags[pmu_pkg::SLOT_EV1] = 1'b0;
            if (v[pmu_pkg::PK_OV_CYC_BIT])
                pmu_flags[pmu_pkg::SLOT_CYC] = 1'b0;
            pmu_sel[0] = v[pmu_pkg::PK_SEL0_LSB +: SW];
            pmu_sel[1] = v[pmu_pkg::PK_SEL1_LSB +: SW];
        end
    endfunction

    // counter slot behind a register index, -1 when none is live
    function automatic int counter_slot(logic [IW-1:0] idx);
        int i;
        i = int'(idx) - int'(pmu_pkg::REG_CYCLES);
        if (i >= 0 && i <= 4 && i <= live_events())
            return i;
        return -1;
    endfunction

    function automatic logic [DW-1:0] reg_value(logic [IW-1:0] idx);
        logic [DW-1:0] v;
        int s;
        v = '0;
        s = counter_slot(idx);
        if (idx == pmu_pkg::REG_CONTROL)
            v = control_value();
        else if (s >= 0)
            v = pmu_count[s];
        else if (pmu_layout == pmu_pkg::LAYOUT_SPLIT)
        begin
            if (idx == pmu_pkg::REG_IRQ_EN)
                v = DW'(pmu_irq_en & live_mask());
            else if (idx == pmu_pkg::REG_FLAGS)
                v = DW'(pmu_flags & live_mask());
            else if (idx == pmu_pkg::REG_EVSEL)
                for (int k = 0; k < live_events(); k++)
                    v[8*k +: SW] = pmu_sel[k];
        end
        return v;
    endfunction

    function automatic void reg_write(logic [IW-1:0] idx, logic [DW-1:0] d);
        int s;
        s = counter_slot(idx);
        if (idx == pmu_pkg::REG_CONTROL)
            control_write(d);
        else if (s >= 0)
            pmu_count[s] = d;
        else if (pmu_layout == pmu_pkg::LAYOUT_SPLIT)
        begin
            if (idx == pmu_pkg::REG_IRQ_EN)
                pmu_irq_en = d[4:0] & live_mask();
            else if (idx == pmu_pkg::REG_FLAGS)
                pmu_flags = pmu_flags & ~d[4:0];
            else if (idx == pmu_pkg::REG_EVSEL)
                for (int k = 0; k < live_events(); k++)
                    pmu_sel[k] = d[8*k +: SW];
        end
    endfunction

    function automatic void bump(int s);
        pmu_count[s] = pmu_count[s] + 1'b1;
        if (pmu_count[s] == '0)
            pmu_flags[s] = 1'b1;
    endfunction

    function automatic void count_tick(logic [DW-1:0] lines);
        if (!pmu_count_on)
            return;
        bump(pmu_pkg::SLOT_CYC);
        for (int k = 0; k < live_events(); k++)
            if (pmu_sel[k] < 32 && lines[pmu_sel[k][4:0]])
                bump(k + 1);
    endfunction

    function automatic readback_t apply_access(access_t a);
        readback_t r;
        r.read_data = '0;
        unique case (a.command)
            pmu_pkg::CMD_TICK:  count_tick(a.event_lines);
            pmu_pkg::CMD_READ:  r.read_data = reg_value(a.reg_index);
            pmu_pkg::CMD_WRITE: reg_write(a.reg_index, a.write_data);
            default:            ;
        endcase
        r.irq = |(pmu_flags & pmu_irq_en & live_mask());
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                readback_q.push_back(apply_access(on_wire));
            if (!item_ch.valid || item_ch.ready)
            begin
                if (access_q.size() > 0 && $urandom_range(99) >= src_idle)
                begin
                    on_wire = access_q.pop_front();
                    item_ch.valid       <= 1'b1;
                    item_ch.command     <= on_wire.command;
                    item_ch.reg_index   <= on_wire.reg_index;
                    item_ch.write_data  <= on_wire.write_data;
                    item_ch.event_lines <= on_wire.event_lines;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        readback_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (readback_q.size() == 0)
                begin
                    report_mismatch("result with nothing expected, read_data",
                                    result_ch.read_data, '0);
                end
                else
                begin
                    want = readback_q.pop_front();
                    if (result_ch.read_data !== want.read_data)
                        report_mismatch("read_data", result_ch.read_data, want.read_data);
                    if (result_ch.irq !== want.irq)
                        report_mismatch("irq", DW'(result_ch.irq), DW'(want.irq));
                end
            end
            result_ch.ready <= !sink_hold && ($urandom_range(99) >= sink_idle);
        end
    end

    task automatic queue_access(pmu_pkg::cmd_t c, logic [IW-1:0] idx, logic [DW-1:0] d,
                                logic [DW-1:0] lines);
        access_t a;
        a.command     = c;
        a.reg_index   = idx;
        a.write_data  = d;
        a.event_lines = lines;
        access_q.push_back(a);
    endtask

    function automatic access_t random_access();
        access_t a;
        int r;
        r = $urandom_range(99);
        if (r < 48)
            a.command = pmu_pkg::CMD_TICK;
        else if (r < 68)
            a.command = pmu_pkg::CMD_READ;
        else if (r < 97)
            a.command = pmu_pkg::CMD_WRITE;
        else
            a.command = pmu_pkg::CMD_NOP;
        if ($urandom_range(9) == 0)
            a.reg_index = IW'($urandom_range(9, 15));
        else
            a.reg_index = IW'($urandom_range(0, 8));
        a.write_data  = $urandom;
        a.event_lines = $urandom;
        r = $urandom_range(9);
        if (r == 0)
            a.event_lines = '1;
        else if (r == 1)
            a.event_lines = '0;
        if (a.command == pmu_pkg::CMD_WRITE)
        begin
            if (a.reg_index == pmu_pkg::REG_CONTROL)
            begin
                a.write_data[pmu_pkg::CTRL_ENABLE_BIT] = ($urandom_range(9) < 8);
                if ($urandom_range(9) < 8)
                begin
                    a.write_data[pmu_pkg::CTRL_CLR_EVENTS_BIT] = 1'b0;
                    a.write_data[pmu_pkg::CTRL_CLR_CYCLES_BIT] = 1'b0;
                end
                if ($urandom_range(3) != 0)
                begin
                    a.write_data[pmu_pkg::PK_SEL0_LSB +: SW] = SW'($urandom_range(0, 35));
                    a.write_data[pmu_pkg::PK_SEL1_LSB +: SW] = SW'($urandom_range(0, 35));
                end
            end
            else if (a.reg_index == pmu_pkg::REG_EVSEL)
            begin
                if ($urandom_range(3) != 0)
                    for (int k = 0; k < 4; k++)
                        a.write_data[8*k +: SW] = SW'($urandom_range(0, 35));
            end
            else if (counter_slot(a.reg_index) >= 0 || a.reg_index <= pmu_pkg::REG_CYCLES + 4)
            begin
                // preload near the top so wraps happen often
                if (a.reg_index >= pmu_pkg::REG_CYCLES && $urandom_range(2) == 0)
                    a.write_data = 32'hFFFF_FFFF - DW'($urandom_range(0, 12));
            end
        end
        return a;
    endfunction

    task automatic queue_random(int n);
        repeat (n)
            access_q.push_back(random_access());
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (access_q.size() > 0 || item_ch.valid || readback_q.size() > 0);
    endtask

    task automatic write_layout(logic value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        @(posedge clk);
        cfg_ch.valid  <= 1'b1;
        cfg_ch.layout <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        pmu_layout = value;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.command     = pmu_pkg::CMD_NOP;
        item_ch.reg_index   = '0;
        item_ch.write_data  = '0;
        item_ch.event_lines = '0;
        result_ch.ready     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.layout       = pmu_pkg::LAYOUT_SPLIT;
        pmu_layout   = pmu_pkg::LAYOUT_SPLIT;
        pmu_count_on = 1'b0;
        pmu_divider  = 1'b0;
        pmu_irq_en   = '0;
        pmu_flags    = '0;
        for (int k = 0; k < 4; k++)
            pmu_sel[k] = '0;
        for (int k = 0; k < 5; k++)
            pmu_count[k] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // five-counter layout, directed
        write_layout(pmu_pkg::LAYOUT_SPLIT);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_CONTROL, '0, '0);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_IRQ_EN, '0, '0);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_FLAGS, '0, '0);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_EVSEL, '0, '0);
        // selects 0, 31, 5 and 32, the last one never counts
        queue_access(pmu_pkg::CMD_WRITE, pmu_pkg::REG_EVSEL, 32'h2005_1F00, '0);
        queue_access(pmu_pkg::CMD_WRITE, pmu_pkg::REG_IRQ_EN, '1, '0);
        queue_access(pmu_pkg::CMD_WRITE, pmu_pkg::REG_CYCLES, 32'hFFFF_FFFE, '0);
        queue_access(pmu_pkg::CMD_WRITE, IW'(pmu_pkg::REG_CYCLES + 1), '1, '0);
        queue_access(pmu_pkg::CMD_WRITE, IW'(pmu_pkg::REG_CYCLES + 4), '1, '0);
        queue_access(pmu_pkg::CMD_WRITE, pmu_pkg::REG_CONTROL, 32'hFFFF_FFF9, '0);
        queue_access(pmu_pkg::CMD_TICK, pmu_pkg::REG_CONTROL, '0, '1);
        queue_access(pmu_pkg::CMD_TICK, pmu_pkg::REG_CONTROL, '0, '0);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_CONTROL, '0, '0);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_FLAGS, '0, '0);
        queue_access(pmu_pkg::CMD_WRITE, pmu_pkg::REG_FLAGS, '1, '0);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_FLAGS, '0, '0);
        queue_access(pmu_pkg::CMD_READ, 4'd9, '0, '0);
        queue_access(pmu_pkg::CMD_READ, 4'd15, '0, '0);
        queue_access(pmu_pkg::CMD_WRITE, 4'd12, '1, '0);
        queue_access(pmu_pkg::CMD_NOP, 4'd15, '1, '1);
        queue_access(pmu_pkg::CMD_WRITE, pmu_pkg::REG_CONTROL, 32'h0000_0007, '0);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_CYCLES, '0, '0);
        queue_access(pmu_pkg::CMD_READ, IW'(pmu_pkg::REG_CYCLES + 2), '0, '0);
        queue_access(pmu_pkg::CMD_WRITE, pmu_pkg::REG_CONTROL, '0, '0);
        queue_access(pmu_pkg::CMD_TICK, pmu_pkg::REG_CONTROL, '0, '1);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_CYCLES, '0, '0);

        // random, with a long receiver hold-off while items keep coming
        queue_random(120);
        @(negedge clk);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        sink_hold = 1'b0;
        queue_random(230);

        // packed three-counter layout
        write_layout(pmu_pkg::LAYOUT_PACKED);
        queue_access(pmu_pkg::CMD_WRITE, pmu_pkg::REG_CONTROL, '1, '0);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_CONTROL, '0, '0);
        queue_access(pmu_pkg::CMD_WRITE, pmu_pkg::REG_CONTROL, 32'h01F0_3071, '0);
        queue_access(pmu_pkg::CMD_WRITE, IW'(pmu_pkg::REG_CYCLES + 1), '1, '0);
        queue_access(pmu_pkg::CMD_WRITE, IW'(pmu_pkg::REG_CYCLES + 2), '1, '0);
        queue_access(pmu_pkg::CMD_WRITE, IW'(pmu_pkg::REG_CYCLES + 3), 32'h5, '0);
        queue_access(pmu_pkg::CMD_READ, IW'(pmu_pkg::REG_CYCLES + 3), '0, '0);
        queue_access(pmu_pkg::CMD_TICK, pmu_pkg::REG_CONTROL, '0, 32'h8000_0008);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_CONTROL, '0, '0);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_IRQ_EN, '0, '0);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_FLAGS, '0, '0);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_EVSEL, '0, '0);
        queue_access(pmu_pkg::CMD_WRITE, pmu_pkg::REG_EVSEL, '1, '0);
        queue_access(pmu_pkg::CMD_WRITE, pmu_pkg::REG_CONTROL, 32'h01F0_3771, '0);
        queue_access(pmu_pkg::CMD_READ, pmu_pkg::REG_CONTROL, '0, '0);
        queue_random(300);

        // five-counter layout again, no idling on either side
        write_layout(pmu_pkg::LAYOUT_SPLIT);
        src_idle  = 0;
        sink_idle = 0;
        queue_random(250);

        write_layout(pmu_pkg::LAYOUT_PACKED);
        src_idle  = 33;
        sink_idle = 33;
        queue_random(150);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS performance_monitor_unit_core");
        else
            $display("FAIL performance_monitor_unit_core");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout waiting for results");
        $display("FAIL performance_monitor_unit_core");
        $finish;
    end

endmodule
